### src/emd_pkg.sv
// Shared types and constants for the error-diffusion mono dither.
package emd_pkg;

	localparam int ERR_W = 14;
	typedef logic signed [ERR_W-1:0] err_t;

	localparam int OUT_W = 32;
	typedef struct packed {
		logic [OUT_W-1:0] word;
		logic             ends_row;
	} out_item_t;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int         LUMA_W     = 18;
	localparam logic [9:0] LUMA_R     = 10'd307;
	localparam logic [9:0] LUMA_G     = 10'd599;
	localparam logic [9:0] LUMA_B     = 10'd118;
	localparam int         LUMA_SHIFT = 10;

	localparam logic [7:0] SPAN_RESET = 8'd255;
	localparam int         CFG_IDX_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOURCE_MODE = 2'd0,
		CFG_MIN_GRAY    = 2'd1,
		CFG_GRAY_SPAN   = 2'd2
	} cfg_idx_t;

endpackage

### src/emd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module emd_ram #(
	parameter int W     = 14,
	parameter int DEPTH = 512,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/emd_line_store.sv
// Error line store: even/odd banked RAMs with write steering and read forwarding.
module emd_line_store import emd_pkg::*; #(
	parameter int MAX_ROW_PIXELS = 1024,
	parameter int IW             = $clog2(MAX_ROW_PIXELS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_idx,
	output err_t          rd_data,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_col,
	input  logic          wr_last,
	input  err_t          wr_cur,
	input  err_t          wr_next
);

	localparam int DE  = MAX_ROW_PIXELS / 2 + 1;
	localparam int DO  = (MAX_ROW_PIXELS + 1) / 2;
	localparam int BWE = (DE > 1) ? $clog2(DE) : 1;
	localparam int BWO = (DO > 1) ? $clog2(DO) : 1;

	logic [IW-1:0]  idx_b;
	logic           wb_en;
	logic           we_e, we_o;
	logic [BWE-1:0] waddr_e, raddr_e;
	logic [BWO-1:0] waddr_o, raddr_o;
	err_t           wdata_e, wdata_o, rdata_e, rdata_o, ram_data;

	logic           wa_en_q, wb_en_q, rd_odd_q;
	logic [IW-1:0]  wa_idx_q, wb_idx_q, rd_idx_q;
	err_t           wa_data_q, wb_data_q;

	assign idx_b = wr_col + IW'(1);
	assign wb_en = wr_en & wr_last;

	assign we_e    = wr_col[0] ? wb_en : wr_en;
	assign we_o    = wr_col[0] ? wr_en : wb_en;
	assign waddr_e = wr_col[0] ? BWE'(idx_b >> 1) : BWE'(wr_col >> 1);
	assign waddr_o = wr_col[0] ? BWO'(wr_col >> 1) : BWO'(idx_b >> 1);
	assign wdata_e = wr_col[0] ? wr_next : wr_cur;
	assign wdata_o = wr_col[0] ? wr_cur : wr_next;
	assign raddr_e = BWE'(rd_idx >> 1);
	assign raddr_o = BWO'(rd_idx >> 1);

	emd_ram #(.W(ERR_W), .DEPTH(DE), .AW(BWE)) u_bank_even (
		.clk   (clk),
		.we    (we_e),
		.waddr (waddr_e),
		.wdata (wdata_e),
		.raddr (raddr_e),
		.rdata (rdata_e)
	);

	emd_ram #(.W(ERR_W), .DEPTH(DO), .AW(BWO)) u_bank_odd (
		.clk   (clk),
		.we    (we_o),
		.waddr (waddr_o),
		.wdata (wdata_o),
		.raddr (raddr_o),
		.rdata (rdata_o)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_en_q <= 1'b0;
			wb_en_q <= 1'b0;
		end else begin
			wa_en_q <= wr_en;
			wb_en_q <= wb_en;
		end
	end

	always_ff @(posedge clk) begin
		wa_idx_q  <= wr_col;
		wb_idx_q  <= idx_b;
		wa_data_q <= wr_cur;
		wb_data_q <= wr_next;
		rd_idx_q  <= rd_idx;
		rd_odd_q  <= rd_idx[0];
	end

	assign ram_data = rd_odd_q ? rdata_o : rdata_e;

	// newest write wins: this cycle's writes, then last cycle's, then the RAM
	always_comb begin
		if (wr_en && wr_col == rd_idx_q) begin
			rd_data = wr_cur;
		end else if (wb_en && idx_b == rd_idx_q) begin
			rd_data = wr_next;
		end else if (wa_en_q && wa_idx_q == rd_idx_q) begin
			rd_data = wa_data_q;
		end else if (wb_en_q && wb_idx_q == rd_idx_q) begin
			rd_data = wb_data_q;
		end else begin
			rd_data = ram_data;
		end
	end

endmodule

### src/emd_out_fifo.sv
// Output word FIFO decoupling the dither pipeline from the result channel.
module emd_out_fifo import emd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  out_item_t             push_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output out_item_t             out_data,
	output logic [FIFO_CNT_W-1:0] count
);

	out_item_t             store_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign out_data  = store_q[rd_ptr_q];
	assign pop       = out_valid & out_ready;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### src/error_diffusion_mono_dither.sv
// Floyd-Steinberg 1-bit mono dither: three-stage pipeline around a banked error line store.
// A row-end or word-full pixel pushes its word into the output FIFO from stage 2; the word then shows on the output.
// Throughput: one pixel per cycle while in_ready is high; the error loop (carry, clamp, threshold) closes in stage 2.
// Input stalls only when the 4-entry output FIFO plus items in flight is full.
// Reset clears config (gray_span 255), pipeline, errors, bit packing and column; the line
// store is not cleared: first_row pixels read zero errors.
module error_diffusion_mono_dither import emd_pkg::*; #(
	parameter int MAX_ROW_PIXELS = 1024,
	parameter int WORD_BITS      = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           red_or_gray,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic                 row_last,
	input  logic                 first_row,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [OUT_W-1:0]     mono_word,
	output logic                 word_ends_row
);

	localparam int IW = $clog2(MAX_ROW_PIXELS + 1);
	localparam int CW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
	localparam int PW = $clog2(WORD_BITS);
	localparam logic [CW-1:0]        COL_LAST = CW'(MAX_ROW_PIXELS - 1);
	localparam logic [PW-1:0]        POS_LAST = PW'(WORD_BITS - 1);
	localparam logic [WORD_BITS-1:0] BIT_TOP  = {1'b1, {(WORD_BITS-1){1'b0}}};

	// configuration
	logic       mode_q;
	logic [7:0] min_q, span_q, thresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			min_q  <= 8'd0;
			span_q <= SPAN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SOURCE_MODE: mode_q <= cfg_wdata[0];
				CFG_MIN_GRAY:    min_q  <= cfg_wdata;
				CFG_GRAY_SPAN:   span_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign thresh = (span_q < 8'd2) ? 8'd1 : (span_q >> 1);

	// stage 0: transfer, column tracking, line store read
	logic                  acc;
	logic [CW-1:0]         col_q;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic                  v_s1, v_s2;

	assign in_ready = (4'(fifo_count) + 4'(v_s1) + 4'(v_s2)) < 4'(FIFO_DEPTH);
	assign acc      = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (acc) begin
			if (row_last) begin
				col_q <= '0;
			end else if (col_q != COL_LAST) begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage 1: luma or gray select, min_gray offset
	logic [7:0]        red_s1, green_s1, blue_s1;
	logic              last_s1, first_s1;
	logic [CW-1:0]     col_s1;
	logic [LUMA_W-1:0] luma_sum;
	logic [7:0]        pix;
	logic signed [9:0] pv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		red_s1   <= red_or_gray;
		green_s1 <= green;
		blue_s1  <= blue;
		last_s1  <= row_last;
		first_s1 <= first_row;
		col_s1   <= col_q;
	end

	assign luma_sum = LUMA_W'(red_s1) * LUMA_W'(LUMA_R)
		+ LUMA_W'(green_s1) * LUMA_W'(LUMA_G)
		+ LUMA_W'(blue_s1) * LUMA_W'(LUMA_B);
	assign pix = mode_q ? luma_sum[LUMA_SHIFT +: 8] : red_s1;
	assign pv  = $signed({2'b00, pix}) - $signed({2'b00, min_q});

	// stage 2: error loop, bit packing, line store write
	err_t              above_rd, above_s2;
	logic signed [9:0] pv_s2;
	logic              last_s2, first_s2;
	logic [CW-1:0]     col_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		above_s2 <= above_rd;
		pv_s2    <= pv;
		last_s2  <= last_s1;
		first_s2 <= first_s1;
		col_s2   <= col_s1;
	end

	err_t                  carry_q, below_q, below_prev_q;
	err_t                  above, e14, e3, e5, e7, line_cur, line_next;
	logic signed [14:0]    tsum;
	logic signed [11:0]    cur;
	logic [7:0]            cl;
	logic                  black, emit;
	logic signed [8:0]     e;
	logic [PW-1:0]         pos_q;
	logic [WORD_BITS-1:0]  word_q, word_next;
	out_item_t             push_data;

	assign above = first_s2 ? '0 : above_s2;
	assign tsum  = $signed({carry_q[ERR_W-1], carry_q}) + $signed({above[ERR_W-1], above})
		+ 15'sd8;
	assign cur   = $signed({tsum[14], tsum[14:4]}) + $signed({{2{pv_s2[9]}}, pv_s2});

	always_comb begin
		if (cur[11]) begin
			cl = 8'd0;
		end else if (cur[10:0] > {3'b000, span_q}) begin
			cl = span_q;
		end else begin
			cl = cur[7:0];
		end
	end

	assign black     = cl < thresh;
	assign e         = black ? $signed({1'b0, cl}) : $signed({1'b0, cl}) - $signed({1'b0, span_q});
	assign e14       = {{(ERR_W-9){e[8]}}, e};
	assign e3        = (e14 <<< 1) + e14;
	assign e5        = (e14 <<< 2) + e14;
	assign e7        = (e14 <<< 3) - e14;
	assign line_cur  = below_prev_q + e3;
	assign line_next = below_q + e5;

	assign word_next = word_q | (black ? (BIT_TOP >> pos_q) : '0);
	assign emit      = v_s2 & (last_s2 | (pos_q == POS_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q      <= '0;
			below_q      <= '0;
			below_prev_q <= '0;
			pos_q        <= '0;
			word_q       <= '0;
		end else if (v_s2) begin
			if (last_s2) begin
				carry_q      <= '0;
				below_q      <= '0;
				below_prev_q <= '0;
			end else begin
				carry_q      <= e7;
				below_q      <= e14;
				below_prev_q <= line_next;
			end
			if (emit) begin
				pos_q  <= '0;
				word_q <= '0;
			end else begin
				pos_q  <= pos_q + PW'(1);
				word_q <= word_next;
			end
		end
	end

	emd_line_store #(.MAX_ROW_PIXELS(MAX_ROW_PIXELS), .IW(IW)) u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (IW'(col_q) + IW'(1)),
		.rd_data (above_rd),
		.wr_en   (v_s2),
		.wr_col  (IW'(col_s2)),
		.wr_last (last_s2),
		.wr_cur  (line_cur),
		.wr_next (line_next)
	);

	// output
	out_item_t out_data;

	assign push_data.word     = OUT_W'(word_next);
	assign push_data.ends_row = last_s2;

	emd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (push_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.count     (fifo_count)
	);

	assign mono_word     = out_data.word;
	assign word_ends_row = out_data.ends_row;

endmodule
